// ===== sv/dlsa_pkg.sv =====
// Shared types, constants and arithmetic step functions for the disk light weight pipeline.
`default_nettype none

package dlsa_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int TRIG_ITERATIONS = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 17;

  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic [31:0]        Q30_PI      = 32'd3373259426;
  localparam logic [16:0]        SPAN_ONE    = 17'd65536;

  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  localparam logic [2:0] REG_TWO_SIDED = 3'd0;
  localparam logic [2:0] REG_CENTER_X  = 3'd1;
  localparam logic [2:0] REG_CENTER_Y  = 3'd2;
  localparam logic [2:0] REG_CENTER_Z  = 3'd3;
  localparam logic [2:0] REG_NORMAL_X  = 3'd4;
  localparam logic [2:0] REG_NORMAL_Y  = 3'd5;
  localparam logic [2:0] REG_NORMAL_Z  = 3'd6;
  localparam logic [2:0] REG_RADIUS    = 3'd7;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
  } ray_t;

  typedef struct packed {
    logic [16:0] span;
    logic        back_rejected;
  } weight_t;

  typedef struct packed {
    logic                          two_sided;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic signed [15:0]            normal_x;
    logic signed [15:0]            normal_y;
    logic signed [15:0]            normal_z;
    logic [30:0]                   radius;
  } cfg_t;

  typedef struct packed {
    logic        back;
    logic [28:0] r;
    logic [59:0] e2;
    logic [29:0] la_x;
    logic [29:0] la_y;
    logic        la_neg;
  } front_t;

  typedef struct packed {
    logic        back;
    logic [30:0] la;
    logic [30:0] ta;
  } angle_t;

  typedef struct packed {
    logic               back;
    logic signed [33:0] x;
    logic signed [33:0] y;
  } rot_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cv_t;

  // One digit of the integer square root; the root is exact after SQRT_STEPS steps.
  function automatic sq_t sqrt_step(sq_t s, int k);
    logic [63:0] bit_v;
    logic [63:0] trial;
    sq_t o;
    bit_v = 64'd1 << (62 - 2 * k);
    trial = s.root + bit_v;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + bit_v;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  // Vectoring micro-rotation: drives y towards zero and accumulates the angle.
  function automatic cv_t vec_step(cv_t s, int i);
    logic signed [33:0] x, y, z, xs, ys, ang;
    cv_t o;
    x   = s.x;
    y   = s.y;
    z   = s.z;
    xs  = x >>> i;
    ys  = y >>> i;
    ang = $signed({4'b0000, ATAN_Q30[i[4:0]]});
    if (y >= 34'sd0) begin
      o.x = x + ys;
      o.y = y - xs;
      o.z = z + ang;
    end else begin
      o.x = x - ys;
      o.y = y + xs;
      o.z = z - ang;
    end
    return o;
  endfunction

  // Rotation micro-rotation: drives the residual angle towards zero.
  function automatic cv_t rot_step(cv_t s, int i);
    logic signed [33:0] x, y, z, xs, ys, ang;
    cv_t o;
    x   = s.x;
    y   = s.y;
    z   = s.z;
    xs  = x >>> i;
    ys  = y >>> i;
    ang = $signed({4'b0000, ATAN_Q30[i[4:0]]});
    if (z >= 34'sd0) begin
      o.x = x - ys;
      o.y = y + xs;
      o.z = z - ang;
    end else begin
      o.x = x + ys;
      o.y = y - xs;
      o.z = z + ang;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/disk_light_solid_angle_estimate.sv =====
// Top level: configuration registers, the four pipeline sections and the output buffer.
`default_nettype none

// Disk light sampling weight. One ray origin word is accepted per clock while ray_stall is
// low, and one weight word comes out for each, in order, after 10 front-end stages, three
// 32-step square roots, two 16-step CORDIC sections and a 17-step divider, one step per
// register stage. The whole pipeline advances together; a two-word buffer at the output
// absorbs stalls, and ray_stall rises only when both of its words are waiting. Configuration
// is written through cfg_we, cfg_index and cfg_data and should only change while no ray is
// in flight. There is no start-up sweep: the block takes rays straight after reset.
module disk_light_solid_angle_estimate
  import dlsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        ray_valid,
  output logic        ray_stall,
  input  ray_t        ray,
  output logic        weight_valid,
  input  logic        weight_stall,
  output weight_t     weight,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  logic    en;
  logic    f_valid, a_valid, t_valid, s_valid;
  front_t  f_word;
  angle_t  a_word;
  rot_t    t_word;
  weight_t s_word;

  logic [1:0] count;
  logic [1:0] fill;
  weight_t    slot [2];
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_sided <= 1'b1;
      cfg.center_x  <= '0;
      cfg.center_y  <= '0;
      cfg.center_z  <= '0;
      cfg.normal_x  <= '0;
      cfg.normal_y  <= '0;
      cfg.normal_z  <= 16'sd16384;
      cfg.radius    <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TWO_SIDED: cfg.two_sided <= cfg_data[0];
        REG_CENTER_X:  cfg.center_x  <= cfg_data;
        REG_CENTER_Y:  cfg.center_y  <= cfg_data;
        REG_CENTER_Z:  cfg.center_z  <= cfg_data;
        REG_NORMAL_X:  cfg.normal_x  <= cfg_data[15:0];
        REG_NORMAL_Y:  cfg.normal_y  <= cfg_data[15:0];
        REG_NORMAL_Z:  cfg.normal_z  <= cfg_data[15:0];
        REG_RADIUS:    cfg.radius    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output buffer has a free word.
  assign en        = count != 2'd2;
  assign ray_stall = !en;

  dlsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ray_valid),
    .in_word   (ray),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_word  (f_word)
  );

  dlsa_angles u_angles (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_word   (f_word),
    .out_valid (a_valid),
    .out_word  (a_word)
  );

  dlsa_theta u_theta (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .in_word   (a_word),
    .out_valid (t_valid),
    .out_word  (t_word)
  );

  dlsa_span u_span (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .in_word   (t_word),
    .out_valid (s_valid),
    .out_word  (s_word)
  );

  assign push = s_valid && en;
  assign pop  = weight_valid && !weight_stall;
  assign fill = count - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && fill == 2'd0) begin
      slot[0] <= s_word;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
    if (push && fill != 2'd0) begin
      slot[1] <= s_word;
    end
  end

  assign weight_valid = count != 2'd0;
  assign weight       = slot[0];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer count out of range");
  a_back_zero: assert property (@(posedge clk) disable iff (rst)
    weight_valid && weight.back_rejected |-> weight.span == 17'd0)
    else $error("rejected word carries a nonzero span");
  a_span_max: assert property (@(posedge clk) disable iff (rst)
    weight_valid |-> weight.span <= SPAN_ONE)
    else $error("span above one");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1)
    else $error("buffer count wrong after a pop");
`endif

endmodule

`default_nettype wire

// ===== sv/dlsa_front.sv =====
// Front end: eye vector, common rescale, dot products and the radial atan2 operands.
`default_nettype none

module dlsa_front
  import dlsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  ray_t   in_word,
  input  cfg_t   cfg,
  output logic   out_valid,
  output front_t out_word
);

  localparam int STAGES   = 10;
  localparam int E_W      = COORD_WIDTH + 1;
  localparam int POS_W    = $clog2(E_W);
  localparam int NORM_LOW = 28;

  logic [STAGES-1:0] valid;

  logic [COORD_WIDTH-1:0] org [3];
  logic [COORD_WIDTH-1:0] cen [3];
  logic signed [15:0]     nrm [3];

  logic signed [E_W-1:0] e1 [3];
  logic [30:0]           r1;
  logic signed [E_W-1:0] e2c [3];
  logic [E_W-1:0]        a2 [3];
  logic [30:0]           r2;
  logic signed [E_W-1:0] e3 [3];
  logic [E_W-1:0]        mx3;
  logic [30:0]           r3;
  logic signed [E_W-1:0] e4 [3];
  logic [POS_W-1:0]      sr4;
  logic [4:0]            sl4;
  logic [30:0]           r4;
  logic signed [29:0]    e5 [3];
  logic [28:0]           r5;
  logic signed [45:0]    p6 [3];
  logic [59:0]           sq6 [3];
  logic [57:0]           rr6;
  logic [28:0]           r6;
  logic signed [47:0]    hr7;
  logic [59:0]           e2_7;
  logic [57:0]           rr7;
  logic [28:0]           r7;
  logic                  back8;
  logic [31:0]           habs8;
  logic signed [60:0]    diff8;
  logic [59:0]           e2_8;
  logic [28:0]           r8;
  logic                  back9;
  logic [61:0]           yl9;
  logic [59:0]           ad9;
  logic                  neg9;
  logic [59:0]           e2_9;
  logic [28:0]           r9;
  front_t                o10;

  logic [E_W-1:0]   m01, m23, mx_c;
  logic [POS_W-1:0] pos_c;
  logic [POS_W-1:0] sr_c;
  logic [4:0]       sl_c;
  logic [47:0]      hmag_c;
  logic [61:0]      wide_c;
  logic [5:0]       wpos_c;
  logic [5:0]       ws_c;

  assign org[0] = in_word.origin_x;
  assign org[1] = in_word.origin_y;
  assign org[2] = in_word.origin_z;
  assign cen[0] = cfg.center_x;
  assign cen[1] = cfg.center_y;
  assign cen[2] = cfg.center_z;
  assign nrm[0] = cfg.normal_x;
  assign nrm[1] = cfg.normal_y;
  assign nrm[2] = cfg.normal_z;

  assign m01  = (a2[0] > a2[1]) ? a2[0] : a2[1];
  assign m23  = (a2[2] > E_W'(r2)) ? a2[2] : E_W'(r2);
  assign mx_c = (m01 > m23) ? m01 : m23;

  // The largest of the eye components and the radius is brought into [2^28, 2^29).
  always_comb begin
    pos_c = '0;
    for (int j = 0; j < E_W; j++) begin
      if (mx3[j]) pos_c = POS_W'(j);
    end
    sr_c = (pos_c > POS_W'(NORM_LOW)) ? POS_W'(pos_c - POS_W'(NORM_LOW)) : '0;
    sl_c = (mx3 != '0 && pos_c < POS_W'(NORM_LOW)) ? 5'(POS_W'(NORM_LOW) - pos_c) : 5'd0;
  end

  assign hmag_c = hr7[47] ? 48'(-hr7) : 48'(hr7);

  // Both radial operands are shifted right together until each is below 2^30.
  always_comb begin
    wide_c = {2'b00, ad9} | yl9;
    wpos_c = '0;
    for (int j = 0; j < 62; j++) begin
      if (wide_c[j]) wpos_c = 6'(j);
    end
    ws_c = (wpos_c >= 6'd30) ? 6'(wpos_c - 6'd29) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k]  <= {org[k][COORD_WIDTH-1], org[k]} - {cen[k][COORD_WIDTH-1], cen[k]};
        a2[k]  <= e1[k][E_W-1] ? E_W'(-e1[k]) : E_W'(e1[k]);
        e2c[k] <= e1[k];
        e3[k]  <= e2c[k];
        e4[k]  <= e3[k];
        e5[k]  <= 30'((e4[k] >>> sr4) <<< sl4);
        p6[k]  <= 46'(e5[k]) * 46'(nrm[k]);
        sq6[k] <= 60'(60'(e5[k]) * 60'(e5[k]));
      end
      r1 <= cfg.radius;
      r2 <= r1;
      mx3 <= mx_c;
      r3 <= r2;
      sr4 <= sr_c;
      sl4 <= sl_c;
      r4 <= r3;
      r5 <= 29'((r4 >> sr4) << sl4);
      rr6 <= 58'(r5) * 58'(r5);
      r6 <= r5;
      hr7 <= 48'(p6[0]) + 48'(p6[1]) + 48'(p6[2]);
      e2_7 <= sq6[0] + sq6[1] + sq6[2];
      rr7 <= rr6;
      r7 <= r6;
      back8 <= !cfg.two_sided && hr7[47];
      habs8 <= 32'(hmag_c >> 14);
      diff8 <= {1'b0, e2_7} - {3'b000, rr7};
      e2_8 <= e2_7;
      r8 <= r7;
      back9 <= back8;
      yl9 <= (62'(r8) * 62'(habs8)) << 1;
      ad9 <= diff8[60] ? 60'(-diff8) : 60'(diff8);
      neg9 <= diff8[60];
      e2_9 <= e2_8;
      r9 <= r8;
      o10.back <= back9;
      o10.r <= r9;
      o10.e2 <= e2_9;
      o10.la_x <= 30'(ad9 >> ws_c);
      o10.la_y <= 30'(yl9 >> ws_c);
      o10.la_neg <= neg9;
    end
  end

  assign out_valid = valid[STAGES-1];
  assign out_word  = o10;

endmodule

`default_nettype wire

// ===== sv/dlsa_angles.sv =====
// Eye distance square root and the two vectoring CORDICs that give La and Ta.
`default_nettype none

module dlsa_angles
  import dlsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  front_t in_word,
  output logic   out_valid,
  output angle_t out_word
);

  localparam int T = TRIG_ITERATIONS;

  typedef struct packed {
    logic back;
    logic la_neg;
    logic la_zero;
    logic ta_zero;
  } side_t;

  logic [SQRT_STEPS-1:0] sq_valid;
  sq_t                   sq_in;
  sq_t                   sq [SQRT_STEPS];
  front_t                fc [SQRT_STEPS];

  logic [T-1:0] cv_valid;
  cv_t          cl_in, ct_in;
  side_t        sd_in;
  cv_t          cl [T];
  cv_t          ct [T];
  side_t        sd [T];

  logic   o_valid;
  angle_t o_word;
  logic [31:0] la_a, ta_a;

  function automatic logic [31:0] clamp_angle(logic signed [33:0] z);
    if (z < 34'sd0) return 32'd0;
    if (z > Q30_HALF_PI) return 32'(Q30_HALF_PI);
    return 32'(z);
  endfunction

  assign sq_in.rem  = 64'(in_word.e2);
  assign sq_in.root = '0;

  assign cl_in.x = 34'(fc[SQRT_STEPS-1].la_x);
  assign cl_in.y = 34'(fc[SQRT_STEPS-1].la_y);
  assign cl_in.z = '0;
  assign ct_in.x = 34'(sq[SQRT_STEPS-1].root[29:0]);
  assign ct_in.y = 34'(fc[SQRT_STEPS-1].r);
  assign ct_in.z = '0;
  assign sd_in.back    = fc[SQRT_STEPS-1].back;
  assign sd_in.la_neg  = fc[SQRT_STEPS-1].la_neg;
  assign sd_in.la_zero = fc[SQRT_STEPS-1].la_y == '0;
  assign sd_in.ta_zero = fc[SQRT_STEPS-1].r == '0;

  // A zero opposite side gives angle zero; a negative adjacent side mirrors to pi - a.
  always_comb begin
    la_a = sd[T-1].la_zero ? 32'd0 : clamp_angle(cl[T-1].z);
    if (sd[T-1].la_neg) la_a = Q30_PI - la_a;
    ta_a = sd[T-1].ta_zero ? 32'd0 : clamp_angle(ct[T-1].z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= '0;
      cv_valid <= '0;
      o_valid  <= 1'b0;
    end else if (en) begin
      sq_valid <= {sq_valid[SQRT_STEPS-2:0], in_valid};
      cv_valid <= {cv_valid[T-2:0], sq_valid[SQRT_STEPS-1]};
      o_valid  <= cv_valid[T-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sqrt_step(sq_in, 0);
      fc[0] <= in_word;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq[k] <= sqrt_step(sq[k-1], k);
        fc[k] <= fc[k-1];
      end
      cl[0] <= vec_step(cl_in, 0);
      ct[0] <= vec_step(ct_in, 0);
      sd[0] <= sd_in;
      for (int i = 1; i < T; i++) begin
        cl[i] <= vec_step(cl[i-1], i);
        ct[i] <= vec_step(ct[i-1], i);
        sd[i] <= sd[i-1];
      end
      o_word.back <= sd[T-1].back;
      o_word.la   <= 31'(la_a >> 1);
      o_word.ta   <= 31'(ta_a);
    end
  end

  assign out_valid = o_valid;
  assign out_word  = o_word;

endmodule

`default_nettype wire

// ===== sv/dlsa_theta.sv =====
// Angle product, its square root theta, and the rotation CORDIC for cos(theta).
`default_nettype none

module dlsa_theta
  import dlsa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  angle_t in_word,
  output logic   out_valid,
  output rot_t   out_word
);

  localparam int T = TRIG_ITERATIONS;

  logic        p_valid;
  logic [61:0] prod;
  logic        p_back;

  logic [SQRT_STEPS-1:0] sq_valid;
  sq_t                   sq_in;
  sq_t                   sq [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_back;

  logic [T-1:0] cv_valid;
  cv_t          cv_in;
  cv_t          cv [T];
  logic [T-1:0] cv_back;

  rot_t o_word;

  assign sq_in.rem  = {2'b00, prod};
  assign sq_in.root = '0;

  assign cv_in.x = Q30_ONE;
  assign cv_in.y = '0;
  assign cv_in.z = 34'(sq[SQRT_STEPS-1].root[30:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      sq_valid <= '0;
      cv_valid <= '0;
    end else if (en) begin
      p_valid  <= in_valid;
      sq_valid <= {sq_valid[SQRT_STEPS-2:0], p_valid};
      cv_valid <= {cv_valid[T-2:0], sq_valid[SQRT_STEPS-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= 62'(in_word.la) * 62'(in_word.ta);
      p_back  <= in_word.back;
      sq[0]   <= sqrt_step(sq_in, 0);
      sq_back <= {sq_back[SQRT_STEPS-2:0], p_back};
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq[k] <= sqrt_step(sq[k-1], k);
      end
      cv[0]   <= rot_step(cv_in, 0);
      cv_back <= {cv_back[T-2:0], sq_back[SQRT_STEPS-1]};
      for (int i = 1; i < T; i++) begin
        cv[i] <= rot_step(cv[i-1], i);
      end
    end
  end

  always_comb begin
    o_word.back = cv_back[T-1];
    o_word.x    = cv[T-1].x;
    o_word.y    = cv[T-1].y;
  end

  assign out_valid = cv_valid[T-1];
  assign out_word  = o_word;

endmodule

`default_nettype wire

// ===== sv/dlsa_span.sv =====
// Vector length, rounded quotient (m - x) / m and saturation into the Q1.16 weight.
`default_nettype none

module dlsa_span
  import dlsa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  rot_t    in_word,
  output logic    out_valid,
  output weight_t out_word
);

  typedef struct packed {
    logic [49:0]          rem;
    logic [31:0]          m;
    logic [DIV_STEPS-1:0] q;
    logic                 back;
    logic                 neg;
    logic                 mzero;
  } div_t;

  typedef struct packed {
    logic        back;
    logic        neg;
    logic [31:0] x;
  } carry_t;

  logic        v0;
  logic [63:0] xx0, yy0;
  carry_t      c0;
  logic        v1;
  logic [63:0] sum1;
  carry_t      c1;

  logic [SQRT_STEPS-1:0] sq_valid;
  sq_t                   sq_in;
  sq_t                   sq [SQRT_STEPS];
  carry_t                sc [SQRT_STEPS];

  logic        vp;
  div_t        dp;
  logic [31:0] m_c;
  logic [49:0] dif_c;

  logic [DIV_STEPS-1:0] dv_valid;
  div_t                 dv [DIV_STEPS];

  logic    o_valid;
  weight_t o_word;

  logic [33:0] ax_c, ay_c;

  // One restoring division step: quotient bits enter at the bottom.
  function automatic div_t div_step(div_t s, int k);
    logic [49:0] sub;
    div_t o;
    o   = s;
    sub = 50'(s.m) << (DIV_STEPS - 1 - k);
    if (s.rem >= sub) begin
      o.rem = s.rem - sub;
      o.q   = {s.q[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.q   = {s.q[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  assign ax_c = in_word.x[33] ? 34'(-in_word.x) : 34'(in_word.x);
  assign ay_c = in_word.y[33] ? 34'(-in_word.y) : 34'(in_word.y);

  assign sq_in.rem  = sum1;
  assign sq_in.root = '0;

  // Dividend is (m - x) * 2^16 plus m / 2 so the quotient comes out rounded.
  assign m_c   = sq[SQRT_STEPS-1].root[31:0];
  assign dif_c = 50'(m_c) - 50'(sc[SQRT_STEPS-1].x);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      sq_valid <= '0;
      vp       <= 1'b0;
      dv_valid <= '0;
      o_valid  <= 1'b0;
    end else if (en) begin
      v0       <= in_valid;
      v1       <= v0;
      sq_valid <= {sq_valid[SQRT_STEPS-2:0], v1};
      vp       <= sq_valid[SQRT_STEPS-1];
      dv_valid <= {dv_valid[DIV_STEPS-2:0], vp};
      o_valid  <= dv_valid[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx0     <= 64'(ax_c[31:0]) * 64'(ax_c[31:0]);
      yy0     <= 64'(ay_c[31:0]) * 64'(ay_c[31:0]);
      c0.back <= in_word.back;
      c0.neg  <= in_word.x[33];
      c0.x    <= in_word.x[31:0];
      sum1    <= xx0 + yy0;
      c1      <= c0;
      sq[0]   <= sqrt_step(sq_in, 0);
      sc[0]   <= c1;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq[k] <= sqrt_step(sq[k-1], k);
        sc[k] <= sc[k-1];
      end
      dp.rem   <= (dif_c << 16) + 50'(m_c >> 1);
      dp.m     <= m_c;
      dp.q     <= '0;
      dp.back  <= sc[SQRT_STEPS-1].back;
      dp.neg   <= sc[SQRT_STEPS-1].neg;
      dp.mzero <= m_c == '0;
      dv[0]    <= div_step(dp, 0);
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv[k] <= div_step(dv[k-1], k);
      end
      o_word.back_rejected <= dv[DIV_STEPS-1].back;
      if (dv[DIV_STEPS-1].back || dv[DIV_STEPS-1].mzero) begin
        o_word.span <= '0;
      end else if (dv[DIV_STEPS-1].neg || dv[DIV_STEPS-1].q > SPAN_ONE) begin
        o_word.span <= SPAN_ONE;
      end else begin
        o_word.span <= dv[DIV_STEPS-1].q;
      end
    end
  end

  assign out_valid = o_valid;
  assign out_word  = o_word;

endmodule

`default_nettype wire

// ===== verif/disk_light_solid_angle_estimate_test.sv =====
// Self-checking testbench for the disk light sampling weight pipeline.
`default_nettype none

module disk_light_solid_angle_estimate_test;
  import dlsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        ray_valid = 1'b0;
  logic        ray_stall;
  ray_t        ray = '0;
  logic        weight_valid;
  logic        weight_stall = 1'b0;
  weight_t     weight;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  disk_light_solid_angle_estimate u_dut (
    .clk(clk), .rst(rst), .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .weight_valid(weight_valid), .weight_stall(weight_stall), .weight(weight),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the disk registers.
  logic        disk_two_sided;
  logic [31:0] disk_center [3];
  logic [15:0] disk_normal [3];
  logic [30:0] disk_radius;

  ray_t    ray_queue [$];
  weight_t weight_queue [$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off = 0;
  int      errors = 0;

  localparam longint ATAN_TAB [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint first_quad_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    if (y == 0) return 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      if (y >= 0) begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += ATAN_TAB[i];
      end else begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    if (z < 0) z = 0;
    if (z > 64'd1686629713) z = 64'd1686629713;
    return z;
  endfunction

  function automatic longint half_plane_angle(longint x, longint unsigned y);
    longint unsigned mx;
    longint a;
    mx = (x < 0) ? -x : x;
    while (mx >= (64'd1 << 30) || y >= (64'd1 << 30)) begin
      mx = mx >> 1;
      y = y >> 1;
    end
    a = first_quad_angle(longint'(mx), longint'(y));
    if (x < 0) a = 64'd3373259426 - a;
    return a;
  endfunction

  function automatic logic [16:0] span_of_angle(longint theta);
    longint x, y, z, nx, ny;
    longint unsigned ax, ay, m, num;
    x = 64'd1073741824;
    y = 0;
    z = theta;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        ny = y + shr_floor(x, i);
        z -= ATAN_TAB[i];
      end else begin
        nx = x + shr_floor(y, i);
        ny = y - shr_floor(x, i);
        z += ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    if (x < 0) return SPAN_ONE;
    ax = x;
    ay = (y < 0) ? -y : y;
    m = int_sqrt(ax * ax + ay * ay);
    if (m == 0) return 17'd0;
    num = (m - ax) << 16;
    num = (num + m / 2) / m;
    return (num > 65536) ? SPAN_ONE : num[16:0];
  endfunction

  function automatic weight_t predict_weight(ray_t r_in);
    weight_t w;
    longint e [3];
    longint org [3];
    longint hr, la, ta;
    longint unsigned r, mx, e2, habs, ae;
    int sr, sl;
    org[0] = r_in.origin_x;
    org[1] = r_in.origin_y;
    org[2] = r_in.origin_z;
    r = disk_radius;
    mx = r;
    hr = 0;
    e2 = 0;
    sr = 0;
    sl = 0;
    for (int k = 0; k < 3; k++) begin
      e[k] = org[k] - longint'($signed(disk_center[k]));
      ae = (e[k] < 0) ? -e[k] : e[k];
      if (ae > mx) mx = ae;
    end
    while ((mx >> sr) >= (64'd1 << 29)) sr++;
    if (mx != 0) while ((mx << sl) < (64'd1 << 28)) sl++;
    r = (r >> sr) << sl;
    for (int k = 0; k < 3; k++) begin
      e[k] = shr_floor(e[k], sr) * (longint'(1) << sl);
      hr += e[k] * longint'($signed(disk_normal[k]));
      ae = (e[k] < 0) ? -e[k] : e[k];
      e2 += ae * ae;
    end
    w = '0;
    if (!disk_two_sided && hr < 0) begin
      w.back_rejected = 1'b1;
      return w;
    end
    habs = ((hr < 0) ? -hr : hr) >> 14;
    la = half_plane_angle(longint'(e2) - longint'(r * r), 2 * r * habs) >>> 1;
    ta = half_plane_angle(longint'(int_sqrt(e2)), r);
    w.span = span_of_angle(longint'(int_sqrt(longint'(la) * longint'(ta))));
    return w;
  endfunction

  // Driver: offers the next pending word, holding it while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (ray_valid && !ray_stall) begin
        weight_queue.push_back(predict_weight(ray));
        void'(ray_queue.pop_front());
      end
      if ((ray_valid && ray_stall) ||
          (ray_queue.size() > (ray_valid && !ray_stall ? 0 : 0) &&
           ray_queue.size() != 0 && !(ray_valid && ray_stall) &&
           $urandom_range(99) >= send_idle_pct)) begin
        ray_valid <= 1'b1;
        if (!(ray_valid && ray_stall)) ray <= ray_queue[0];
      end else begin
        ray_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk) begin
    weight_t exp_w;
    if (!rst) begin
      if (weight_valid && !weight_stall) begin
        if (weight_queue.size() == 0) begin
          $error("unexpected weight word %h", weight);
          errors++;
        end else begin
          exp_w = weight_queue.pop_front();
          if (weight.span !== exp_w.span) begin
            $error("span expected %0d actual %0d", exp_w.span, weight.span);
            errors++;
          end
          if (weight.back_rejected !== exp_w.back_rejected) begin
            $error("back_rejected expected %0d actual %0d", exp_w.back_rejected,
                   weight.back_rejected);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        weight_stall <= 1'b1;
      end else begin
        weight_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TWO_SIDED: disk_two_sided = val[0];
      REG_CENTER_X:  disk_center[0] = val;
      REG_CENTER_Y:  disk_center[1] = val;
      REG_CENTER_Z:  disk_center[2] = val;
      REG_NORMAL_X:  disk_normal[0] = val[15:0];
      REG_NORMAL_Y:  disk_normal[1] = val[15:0];
      REG_NORMAL_Z:  disk_normal[2] = val[15:0];
      default:       disk_radius = val[30:0];
    endcase
  endtask

  task automatic drain();
    while (ray_queue.size() != 0 || ray_valid || weight_queue.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic ray_t near_ray(int spread);
    ray_t r_out;
    r_out.origin_x = $signed(disk_center[0]) + $signed($urandom_range(2 * spread) - spread);
    r_out.origin_y = $signed(disk_center[1]) + $signed($urandom_range(2 * spread) - spread);
    r_out.origin_z = $signed(disk_center[2]) + $signed($urandom_range(2 * spread) - spread);
    return r_out;
  endfunction

  task automatic push_ray(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    ray_t r_out;
    r_out.origin_x = x;
    r_out.origin_y = y;
    r_out.origin_z = z;
    ray_queue.push_back(r_out);
  endtask

  function automatic logic [31:0] rand_normal();
    return {{16{1'b0}}, 16'($signed($urandom_range(32768)) - 16384)};
  endfunction

  initial begin
    ray_t r_out;
    disk_two_sided = 1'b1;
    disk_center = '{32'd0, 32'd0, 32'd0};
    disk_normal = '{16'd0, 16'd0, 16'd16384};
    disk_radius = 31'd65536;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words against the reset disk: centre, axis, extremes and behind.
    push_ray(32'd0, 32'd0, 32'd0);
    push_ray(32'd0, 32'd0, 32'd196608);
    push_ray(32'd0, 32'd0, 32'hFFFD0000);
    push_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_ray(32'h80000000, 32'h80000000, 32'h80000000);
    push_ray(32'h7FFFFFFF, 32'h80000000, 32'd1);
    push_ray(32'd65536, 32'd0, 32'd0);
    push_ray(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA);
    drain();

    write_reg(REG_TWO_SIDED, 32'd0);
    push_ray(32'd0, 32'd0, 32'hFFFF0000);
    push_ray(32'd0, 32'd0, 32'd65536);
    push_ray(32'd100, 32'd0, 32'd0);
    drain();
    write_reg(REG_RADIUS, 32'd0);
    push_ray(32'd0, 32'd0, 32'd0);
    push_ray(32'd12345, 32'd0, 32'd65536);
    drain();
    write_reg(REG_RADIUS, 32'h7FFFFFFF);
    write_reg(REG_NORMAL_X, 32'd0);
    write_reg(REG_NORMAL_Y, 32'hFFFFC000);
    write_reg(REG_NORMAL_Z, 32'd0);
    write_reg(REG_CENTER_X, 32'h80000000);
    write_reg(REG_CENTER_Y, 32'h7FFFFFFF);
    write_reg(REG_CENTER_Z, 32'd0);
    push_ray(32'h7FFFFFFF, 32'h80000000, 32'd0);
    push_ray(32'h80000000, 32'h7FFFFFFF, 32'd0);
    push_ray(32'd0, 32'd0, 32'd0);
    drain();
    // Non-unit normal used as given.
    write_reg(REG_NORMAL_X, 32'd16384);
    write_reg(REG_NORMAL_Y, 32'd16384);
    push_ray(32'd0, 32'd0, 32'd0);
    push_ray(32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF);
    drain();

    // Random phases, each with a freshly chosen disk and idling mix. The long hold-off
    // phases carry enough words that the sender is still offering once the block fills.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_off = 600; end
      endcase
      write_reg(REG_TWO_SIDED, $urandom_range(1));
      write_reg(REG_CENTER_X, (phase == 9) ? 32'h80000000 : $urandom);
      write_reg(REG_CENTER_Y, $urandom & 32'h00FFFFFF);
      write_reg(REG_CENTER_Z, (phase == 9) ? 32'h7FFFFFFF : $urandom);
      write_reg(REG_NORMAL_X, rand_normal());
      write_reg(REG_NORMAL_Y, rand_normal());
      write_reg(REG_NORMAL_Z, (phase == 8) ? 32'hFFFFC000 : rand_normal());
      write_reg(REG_RADIUS, (phase % 3 == 0) ? ($urandom & 32'h7FFFFFFF)
                                             : $urandom_range(32'h00100000));
      for (int n = 0; n < ((phase % 5 == 4) ? 180 : 22); n++) begin
        if ($urandom_range(3) == 0) begin
          r_out.origin_x = $urandom;
          r_out.origin_y = $urandom;
          r_out.origin_z = $urandom;
        end else begin
          r_out = near_ray(32'h00400000);
        end
        ray_queue.push_back(r_out);
      end
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
